// ===== rtl/fly_camera_orientation_update_unit_defines.svh =====
// Assertion macros shared by the fly camera checker.
`ifndef FLY_CAMERA_ORIENTATION_UPDATE_UNIT_DEFINES_SVH
`define FLY_CAMERA_ORIENTATION_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the clock, off during reset.
`define FCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the clock, off during reset.
`define FCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fcu_pkg.sv =====
// Shared types, constants, tables and rounding functions of the fly camera unit.
package fcu_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int POS_W = 32;
  localparam int ATAN_N = 24;
  localparam int STEP_W = $clog2(ATAN_N);
  localparam int DEG_STEP = 45;

  localparam logic [16:0] HALF_TURN = 17'd46080;
  localparam logic [24:0] FULL_TURN = 25'd92160;
  localparam logic signed [26:0] WRAP_BIAS = 27'sd11842560;
  localparam logic signed [25:0] ELEV_LIM = 26'sd22784;
  localparam logic signed [19:0] ONE_Q14 = 20'sd16384;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic [10:0] DIV45_MUL = 11'd1456;

  localparam logic OP_LOOK = 1'b0;
  localparam logic OP_MOVE = 1'b1;
  localparam logic REG_SPEED = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  localparam logic [31:0] ATAN_TBL [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef logic [21:0] ang_tbl_t [DEG_STEP];

  // Binary angle of each residue modulo 45 of an angle in 1/256 degrees, in Q.32 turns.
  function automatic ang_tbl_t build_ang_tbl();
    ang_tbl_t t;
    for (int i = 0; i < DEG_STEP; i++) begin
      t[i] = 22'((longint'(i) * 64'sd2097152 + 64'sd22) / DEG_STEP);
    end
    return t;
  endfunction

  localparam ang_tbl_t ANG_TBL = build_ang_tbl();

  typedef enum logic [1:0] {C_IDLE, C_DIV, C_ANG, C_ROT} cordic_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LK_MH, S_LK_MV, S_LK_EL, S_LK_WRAP, S_LK_CH, S_LK_WH, S_LK_CE, S_LK_WE,
    S_LK_F0, S_LK_F1, S_LK_F2, S_MV_CH, S_MV_WH, S_MV_SP, S_MV_SV, S_MV_KEY,
    S_MV_MUL, S_MV_ADD, S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic signed [16:0] angle;
  } cordic_ctl_t;

  typedef struct packed {
    logic done;
  } cordic_sts_t;

  function automatic logic signed [15:0] q14_of_q30(logic signed [31:0] v);
    logic signed [32:0] s;
    logic signed [19:0] t;
    s = 33'(v) + 33'sd32768;
    t = 20'($signed(s[32:16]));
    if (t > ONE_Q14) t = ONE_Q14;
    else if (t < -ONE_Q14) t = -ONE_Q14;
    return 16'(t);
  endfunction

  function automatic logic signed [15:0] q14_of_q60(logic signed [65:0] v);
    logic signed [65:0] s;
    logic signed [19:0] t;
    s = v + (66'sd1 <<< 45);
    t = s[65:46];
    if (t > ONE_Q14) t = ONE_Q14;
    else if (t < -ONE_Q14) t = -ONE_Q14;
    return 16'(t);
  endfunction

endpackage

// ===== rtl/fcu_cordic.sv =====
// Iterative sine and cosine unit: degree to binary angle, fold, CORDIC rotation.
module fcu_cordic (
  input  logic                     clk,
  input  logic                     rst,
  input  fcu_pkg::cordic_ctl_t     ctl,
  output fcu_pkg::cordic_sts_t     sts,
  output logic signed [31:0]       sin_val,
  output logic signed [31:0]       cos_val
);

  fcu_pkg::cordic_state_t state, state_next;
  logic [16:0] dsh;
  logic [10:0] qe;
  logic signed [31:0] x, y;
  logic signed [33:0] a;
  logic flip;
  logic [fcu_pkg::STEP_W-1:0] step;
  logic done;

  logic [27:0] div_prod;
  logic [16:0] rem;
  logic rem_big;
  logic [5:0] r_idx;
  logic [11:0] q_fix;
  logic signed [12:0] q_deg;
  logic signed [33:0] a_raw, a_fold;
  logic fold;
  logic signed [31:0] sx, sy;
  logic signed [33:0] atn;
  logic last;

  always_comb begin
    div_prod = dsh * fcu_pkg::DIV45_MUL;
    rem = dsh - 17'(qe * 17'd45);
    rem_big = rem >= 17'd45;
    r_idx = rem_big ? 6'(rem - 17'd45) : 6'(rem);
    q_fix = 12'(qe) + 12'(rem_big);
    q_deg = $signed({1'b0, q_fix}) - 13'sd1024;
    a_raw = $signed({q_deg, 21'b0}) + $signed({12'b0, fcu_pkg::ANG_TBL[r_idx]});
    fold = 1'b0;
    a_fold = a_raw;
    if (a_raw > fcu_pkg::QUARTER) begin
      a_fold = a_raw - (fcu_pkg::QUARTER <<< 1);
      fold = 1'b1;
    end else if (a_raw < -fcu_pkg::QUARTER) begin
      a_fold = a_raw + (fcu_pkg::QUARTER <<< 1);
      fold = 1'b1;
    end
    sx = x >>> step;
    sy = y >>> step;
    atn = $signed({2'b0, fcu_pkg::ATAN_TBL[step]});
    last = step == fcu_pkg::STEP_W'(fcu_pkg::CORDIC_STEPS - 1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fcu_pkg::C_IDLE: if (ctl.start) state_next = fcu_pkg::C_DIV;
      fcu_pkg::C_DIV: state_next = fcu_pkg::C_ANG;
      fcu_pkg::C_ANG: state_next = fcu_pkg::C_ROT;
      fcu_pkg::C_ROT: if (last) state_next = fcu_pkg::C_IDLE;
      default: state_next = fcu_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcu_pkg::C_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == fcu_pkg::C_ROT) && last;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      fcu_pkg::C_IDLE: begin
        dsh <= 17'(ctl.angle + $signed(fcu_pkg::HALF_TURN));
      end
      fcu_pkg::C_DIV: begin
        qe <= div_prod[26:16];
      end
      fcu_pkg::C_ANG: begin
        a <= a_fold;
        flip <= fold;
        x <= fcu_pkg::CORDIC_GAIN;
        y <= '0;
        step <= '0;
      end
      fcu_pkg::C_ROT: begin
        if (a >= 0) begin
          x <= x - sy;
          y <= y + sx;
          a <= a - atn;
        end else begin
          x <= x + sy;
          y <= y - sx;
          a <= a + atn;
        end
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.done = done;
  assign cos_val = flip ? -x : x;
  assign sin_val = flip ? -y : y;

endmodule

// ===== rtl/fly_camera_orientation_update_unit.sv =====
// Fly camera unit: look and move requests share one CORDIC rotator and the single 33x33
// multiplier. One request is worked at a time; the next request can be taken in the cycle
// after the result is registered, while that result still waits in the output register.
// Synchronous reset restores the registers to their defaults, heading to -90 degrees,
// elevation and position to zero and facing to (0, 0, -1).
module fly_camera_orientation_update_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [15:0] look_dx,
  input  logic signed [15:0] look_dy,
  input  logic [3:0]         move_keys,
  input  logic [15:0]        time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] place_x,
  output logic signed [31:0] place_y,
  output logic signed [31:0] place_z,
  output logic signed [15:0] aim_x,
  output logic signed [15:0] aim_y,
  output logic signed [15:0] aim_z,
  output logic signed [16:0] heading_now,
  output logic signed [15:0] elevation_now
);

  localparam int PW = fcu_pkg::POS_W;
  localparam logic signed [PW+1:0] P_MAX = {3'b000, {(PW-1){1'b1}}};
  localparam logic signed [PW+1:0] P_MIN = {3'b111, {(PW-1){1'b0}}};

  fcu_pkg::seq_state_t state, state_next;
  fcu_pkg::cordic_ctl_t cctl;
  fcu_pkg::cordic_sts_t csts;
  logic signed [31:0] c_sin, c_cos;

  logic [15:0] move_speed, look_gain;
  logic signed [16:0] heading;
  logic signed [15:0] elevation;
  logic signed [PW-1:0] position [3];
  logic signed [15:0] facing [3];

  logic signed [15:0] dx, dy;
  logic [3:0] keys;
  logic [15:0] ts;
  logic [24:0] hacc;
  logic [2:0] wk;
  logic signed [31:0] sh, ch, sp, cp;
  logic signed [15:0] rx, rz;
  logic [31:0] step;
  logic [1:0] kk, comp;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic accept, emit;
  logic signed [65:0] rnd8, rnd22;
  logic signed [24:0] dlt;
  logic signed [26:0] hsum;
  logic signed [25:0] esum;
  logic [24:0] lim, hacc_after;
  logic signed [15:0] dir;
  logic dir_neg;
  logic signed [25:0] disp;
  logic signed [PW+1:0] psum;

  assign accept = in_valid && !in_stall;
  assign in_stall = state != fcu_pkg::S_IDLE;
  assign emit = (state == fcu_pkg::S_EMIT) && (!out_valid || !out_stall);
  assign pready = 1'b1;
  assign prdata = {16'b0, (paddr[2] == fcu_pkg::REG_GAIN) ? look_gain : move_speed};

  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed <= 16'd1280;
      look_gain <= 16'd6554;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        fcu_pkg::REG_SPEED: move_speed <= pwdata[15:0];
        fcu_pkg::REG_GAIN: look_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cctl.start = (state == fcu_pkg::S_LK_CH) || (state == fcu_pkg::S_LK_CE) ||
                 (state == fcu_pkg::S_MV_CH);
    cctl.angle = (state == fcu_pkg::S_LK_CE) ? 17'(elevation) : heading;
  end

  fcu_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .ctl     (cctl),
    .sts     (csts),
    .sin_val (c_sin),
    .cos_val (c_cos)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      fcu_pkg::S_LK_MH: begin
        mul_a = 33'(dx);
        mul_b = $signed({17'b0, look_gain});
      end
      fcu_pkg::S_LK_MV: begin
        mul_a = 33'(dy);
        mul_b = $signed({17'b0, look_gain});
      end
      fcu_pkg::S_LK_F0: begin
        mul_a = 33'(ch);
        mul_b = 33'(cp);
      end
      fcu_pkg::S_LK_F1: begin
        mul_a = 33'(sh);
        mul_b = 33'(cp);
      end
      fcu_pkg::S_MV_SP: begin
        mul_a = $signed({17'b0, move_speed});
        mul_b = $signed({17'b0, ts});
      end
      fcu_pkg::S_MV_MUL: begin
        mul_a = $signed({1'b0, step});
        mul_b = 33'(dir);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    rnd8 = prod + 66'sd128;
    dlt = rnd8[32:8];
    hsum = 27'(heading) + 27'(dlt) + fcu_pkg::WRAP_BIAS;
    esum = 26'(elevation) + 26'(dlt);
    if (esum > fcu_pkg::ELEV_LIM) esum = fcu_pkg::ELEV_LIM;
    else if (esum < -fcu_pkg::ELEV_LIM) esum = -fcu_pkg::ELEV_LIM;
    lim = fcu_pkg::FULL_TURN << wk;
    hacc_after = (hacc >= lim) ? hacc - lim : hacc;
    unique case (comp)
      2'd0: dir = kk[1] ? rx : facing[0];
      2'd1: dir = kk[1] ? 16'sd0 : facing[1];
      default: dir = kk[1] ? rz : facing[2];
    endcase
    dir_neg = (kk == 2'd1) || (kk == 2'd2);
    rnd22 = prod + (66'sd1 <<< 21);
    disp = rnd22[47:22];
    psum = dir_neg ? (PW+2)'(position[comp]) - (PW+2)'(disp)
                   : (PW+2)'(position[comp]) + (PW+2)'(disp);
    if (psum > P_MAX) psum = P_MAX;
    else if (psum < P_MIN) psum = P_MIN;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fcu_pkg::S_IDLE: begin
        if (accept) state_next = (operation == fcu_pkg::OP_MOVE) ? fcu_pkg::S_MV_CH
                                                                  : fcu_pkg::S_LK_MH;
      end
      fcu_pkg::S_LK_MH: state_next = fcu_pkg::S_LK_MV;
      fcu_pkg::S_LK_MV: state_next = fcu_pkg::S_LK_EL;
      fcu_pkg::S_LK_EL: state_next = fcu_pkg::S_LK_WRAP;
      fcu_pkg::S_LK_WRAP: if (wk == 3'd0) state_next = fcu_pkg::S_LK_CH;
      fcu_pkg::S_LK_CH: state_next = fcu_pkg::S_LK_WH;
      fcu_pkg::S_LK_WH: if (csts.done) state_next = fcu_pkg::S_LK_CE;
      fcu_pkg::S_LK_CE: state_next = fcu_pkg::S_LK_WE;
      fcu_pkg::S_LK_WE: if (csts.done) state_next = fcu_pkg::S_LK_F0;
      fcu_pkg::S_LK_F0: state_next = fcu_pkg::S_LK_F1;
      fcu_pkg::S_LK_F1: state_next = fcu_pkg::S_LK_F2;
      fcu_pkg::S_LK_F2: state_next = fcu_pkg::S_EMIT;
      fcu_pkg::S_MV_CH: state_next = fcu_pkg::S_MV_WH;
      fcu_pkg::S_MV_WH: if (csts.done) state_next = fcu_pkg::S_MV_SP;
      fcu_pkg::S_MV_SP: state_next = fcu_pkg::S_MV_SV;
      fcu_pkg::S_MV_SV: state_next = fcu_pkg::S_MV_KEY;
      fcu_pkg::S_MV_KEY: begin
        if (keys[kk]) state_next = fcu_pkg::S_MV_MUL;
        else if (kk == 2'd3) state_next = fcu_pkg::S_EMIT;
      end
      fcu_pkg::S_MV_MUL: state_next = fcu_pkg::S_MV_ADD;
      fcu_pkg::S_MV_ADD: begin
        if (comp != 2'd2) state_next = fcu_pkg::S_MV_MUL;
        else if (kk == 2'd3) state_next = fcu_pkg::S_EMIT;
        else state_next = fcu_pkg::S_MV_KEY;
      end
      fcu_pkg::S_EMIT: if (emit) state_next = fcu_pkg::S_IDLE;
      default: state_next = fcu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcu_pkg::S_IDLE;
      out_valid <= 1'b0;
      heading <= -17'sd23040;
      elevation <= '0;
      position[0] <= '0;
      position[1] <= '0;
      position[2] <= '0;
      facing[0] <= '0;
      facing[1] <= '0;
      facing[2] <= -16'sd16384;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        fcu_pkg::S_LK_EL: elevation <= 16'(esum);
        fcu_pkg::S_LK_WRAP: begin
          if (wk == 3'd0) heading <= $signed(17'(hacc_after) - fcu_pkg::HALF_TURN);
        end
        fcu_pkg::S_LK_F1: facing[0] <= fcu_pkg::q14_of_q60(prod);
        fcu_pkg::S_LK_F2: begin
          facing[2] <= fcu_pkg::q14_of_q60(prod);
          facing[1] <= fcu_pkg::q14_of_q30(sp);
        end
        fcu_pkg::S_MV_ADD: position[comp] <= PW'(psum);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx <= look_dx;
      dy <= look_dy;
      keys <= move_keys;
      ts <= time_step;
    end
    unique case (state)
      fcu_pkg::S_LK_MV: begin
        hacc <= 25'(hsum);
        wk <= 3'd7;
      end
      fcu_pkg::S_LK_WRAP: begin
        hacc <= hacc_after;
        wk <= wk - 3'd1;
      end
      fcu_pkg::S_LK_WH: if (csts.done) begin
        sh <= c_sin;
        ch <= c_cos;
      end
      fcu_pkg::S_LK_WE: if (csts.done) begin
        sp <= c_sin;
        cp <= c_cos;
      end
      fcu_pkg::S_MV_WH: if (csts.done) begin
        rx <= -fcu_pkg::q14_of_q30(c_sin);
        rz <= fcu_pkg::q14_of_q30(c_cos);
      end
      fcu_pkg::S_MV_SV: begin
        step <= prod[31:0];
        kk <= 2'd0;
        comp <= 2'd0;
      end
      fcu_pkg::S_MV_KEY: begin
        comp <= 2'd0;
        if (!keys[kk]) kk <= kk + 2'd1;
      end
      fcu_pkg::S_MV_ADD: begin
        if (comp == 2'd2) begin
          comp <= 2'd0;
          kk <= kk + 2'd1;
        end else begin
          comp <= comp + 2'd1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      place_x <= 32'(position[0]);
      place_y <= 32'(position[1]);
      place_z <= 32'(position[2]);
      aim_x <= facing[0];
      aim_y <= facing[1];
      aim_z <= facing[2];
      heading_now <= heading;
      elevation_now <= elevation;
    end
  end

endmodule

// ===== rtl/fcu_checker.sv =====
// Port-level checks of the fly camera unit and their binding to the top level.
`include "fly_camera_orientation_update_unit_defines.svh"

module fcu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] aim_x,
  input logic signed [15:0] aim_z,
  input logic signed [15:0] elevation_now
);

  `FCU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `FCU_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "request taken while busy")
  `FCU_ASSERT_NOW(a_aim, out_valid, aim_x >= -16'sd16384 && aim_x <= 16'sd16384 && aim_z >= -16'sd16384 && aim_z <= 16'sd16384, "facing out of range")
  `FCU_ASSERT_NOW(a_elev, out_valid, elevation_now >= -16'sd22784 && elevation_now <= 16'sd22784, "elevation beyond limit")

endmodule

bind fly_camera_orientation_update_unit fcu_checker u_fcu_checker (.*);

// ===== bench/fly_camera_check.sv =====
// Checker for the fly camera unit: mirrors its state, predicts each result and compares.
`timescale 1ns / 100ps
module fly_camera_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               operation,
  input  logic signed [15:0] look_dx,
  input  logic signed [15:0] look_dy,
  input  logic [3:0]         move_keys,
  input  logic [15:0]        time_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] place_x,
  input  logic signed [31:0] place_y,
  input  logic signed [31:0] place_z,
  input  logic signed [15:0] aim_x,
  input  logic signed [15:0] aim_y,
  input  logic signed [15:0] aim_z,
  input  logic signed [16:0] heading_now,
  input  logic signed [15:0] elevation_now,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] ax, ay, az;
    logic signed [16:0] hd;
    logic signed [15:0] el;
  } camera_view_t;

  localparam longint ANGLE_STEP [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  longint speed, gain, hdg, elev;
  longint pos [3];
  longint aim [3];
  camera_view_t view_q [$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unit_q14(longint v, int s);
    return clip(rshift(v, s), -16384, 16384);
  endfunction

  task automatic trig(input longint deg, output longint sn, output longint cs);
    longint v, a, x, y, nx;
    bit flip;
    v = deg * 64'sd16777216 + 64'sd180;
    a = v / 64'sd360;
    if (v % 64'sd360 != 0 && v < 0) a--;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (a > 64'sd1073741824) begin
      a -= 64'sd2147483648;
      flip = 1;
    end else if (a < -64'sd1073741824) begin
      a += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < fcu_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (a >= 0) begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        a -= ANGLE_STEP[i];
      end else begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        a += ANGLE_STEP[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  task automatic shift_place(input longint step, input longint dir [3], input int sgn);
    longint d;
    for (int k = 0; k < 3; k++) begin
      d = rshift(step * dir[k], 22);
      pos[k] = clip(pos[k] + (sgn > 0 ? d : -d), -(64'sd1 <<< (fcu_pkg::POS_W - 1)),
                    (64'sd1 <<< (fcu_pkg::POS_W - 1)) - 1);
    end
  endtask

  task automatic advance_camera(input logic op, input logic signed [15:0] dx,
                                input logic signed [15:0] dy, input logic [3:0] keys,
                                input logic [15:0] dt);
    longint sh, ch, sp, cp, h, m, step;
    longint side [3];
    camera_view_t v;
    if (op == fcu_pkg::OP_LOOK) begin
      h = hdg + rshift(longint'(dx) * gain, 8) + 46080;
      m = h % 92160;
      if (m < 0) m += 92160;
      hdg = m - 46080;
      elev = clip(elev + rshift(longint'(dy) * gain, 8), -22784, 22784);
      trig(hdg, sh, ch);
      trig(elev, sp, cp);
      aim[0] = unit_q14(ch * cp, 46);
      aim[1] = unit_q14(sp, 16);
      aim[2] = unit_q14(sh * cp, 46);
    end else begin
      step = speed * longint'(dt);
      trig(hdg, sh, ch);
      side[0] = -unit_q14(sh, 16);
      side[1] = 0;
      side[2] = unit_q14(ch, 16);
      if (keys[0]) shift_place(step, aim, 1);
      if (keys[1]) shift_place(step, aim, -1);
      if (keys[2]) shift_place(step, side, -1);
      if (keys[3]) shift_place(step, side, 1);
    end
    v.px = 32'(pos[0]); v.py = 32'(pos[1]); v.pz = 32'(pos[2]);
    v.ax = 16'(aim[0]); v.ay = 16'(aim[1]); v.az = 16'(aim[2]);
    v.hd = 17'(hdg); v.el = 16'(elev);
    view_q.push_back(v);
  endtask

  task automatic compare(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    camera_view_t w;
    if (rst) begin
      speed = 1280; gain = 6554; hdg = -23040; elev = 0;
      pos = '{0, 0, 0};
      aim = '{0, 0, -16384};
      view_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == fcu_pkg::REG_SPEED) speed = pwdata[15:0];
        else gain = pwdata[15:0];
      end
      if (out_valid && !out_stall) begin
        if (view_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          w = view_q.pop_front();
          compare("place_x", w.px, place_x);
          compare("place_y", w.py, place_y);
          compare("place_z", w.pz, place_z);
          compare("aim_x", w.ax, aim_x);
          compare("aim_y", w.ay, aim_y);
          compare("aim_z", w.az, aim_z);
          compare("heading_now", w.hd, heading_now);
          compare("elevation_now", w.el, elevation_now);
        end
      end
      if (in_valid && !in_stall)
        advance_camera(operation, look_dx, look_dy, move_keys, time_step);
    end
    pending = view_q.size();
  end
endmodule

// ===== bench/tb_fly_camera_orientation_update_unit.sv =====
// Testbench top for the fly camera unit: stimulus, register writes, stalls and verdict.
`timescale 1ns / 100ps
module tb_fly_camera_orientation_update_unit;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, operation = 0;
  logic signed [15:0] look_dx = 0, look_dy = 0;
  logic [3:0] move_keys = 0;
  logic [15:0] time_step = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] place_x, place_y, place_z;
  logic signed [15:0] aim_x, aim_y, aim_z, elevation_now;
  logic signed [16:0] heading_now;
  int errors, pending;
  int hold_off = 0;
  bit hold_req = 0, hold_seen = 0;
  bit starve = 0;

  always #5 clk = ~clk;

  fly_camera_orientation_update_unit u_top (.*);
  fly_camera_check u_check (.*);

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= {16'b0, val};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send(input logic op, input logic signed [15:0] dx,
                      input logic signed [15:0] dy, input logic [3:0] keys,
                      input logic [15:0] dt);
    in_valid <= 1; operation <= op; look_dx <= dx; look_dy <= dy;
    move_keys <= keys; time_step <= dt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(input bit big);
    logic [15:0] dt;
    dt = big ? 16'($urandom) : 16'($urandom_range(0, 3000));
    send(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 4'($urandom), dt);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= 400;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (starve) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    starve = 1;
    send(fcu_pkg::OP_LOOK, 0, 0, 0, 0);
    send(fcu_pkg::OP_MOVE, 0, 0, 4'b0001, 16'hFFFF);
    send(fcu_pkg::OP_LOOK, 16'sd32767, 16'sd32767, 4'hF, 16'hFFFF);
    send(fcu_pkg::OP_LOOK, -16'sd32768, -16'sd32768, 0, 0);
    send(fcu_pkg::OP_LOOK, 16'sd1800, 16'sd0, 0, 0);
    send(fcu_pkg::OP_LOOK, -16'sd1800, 16'sd900, 0, 0);
    send(fcu_pkg::OP_MOVE, 0, 0, 4'b0010, 16'd6554);
    send(fcu_pkg::OP_MOVE, 0, 0, 4'b0100, 16'd6554);
    send(fcu_pkg::OP_MOVE, 0, 0, 4'b1000, 16'd6554);
    send(fcu_pkg::OP_MOVE, 16'sd5, 16'sd5, 4'hF, 16'hFFFF);
    send(fcu_pkg::OP_MOVE, 0, 0, 4'b0000, 16'hFFFF);
    send(fcu_pkg::OP_LOOK, 16'sd450, -16'sd1800, 0, 0);
    starve = 0;
    drain();
    write_reg(fcu_pkg::REG_SPEED, 16'hFFFF);
    write_reg(fcu_pkg::REG_GAIN, 16'hFFFF);
    for (int i = 0; i < 10; i++) send(fcu_pkg::OP_LOOK, 16'($urandom), 16'($urandom), 0, 0);
    for (int i = 0; i < 12; i++) send(fcu_pkg::OP_MOVE, 0, 0, 4'b0001, 16'hFFFF);
    drain();
    write_reg(fcu_pkg::REG_SPEED, 16'h0000);
    write_reg(fcu_pkg::REG_GAIN, 16'h0000);
    for (int i = 0; i < 10; i++) send_random(1);
    hold_req = ~hold_req;
    for (int i = 0; i < 10; i++) send_random(0);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(fcu_pkg::REG_SPEED, 16'($urandom));
      write_reg(fcu_pkg::REG_GAIN, 16'($urandom_range(0, 8000)));
      for (int i = 0; i < 100; i++) send_random($urandom_range(0, 9) == 0);
      drain();
    end
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
